// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/mwt_pkg.sv =====
// ----------------------------------------------------------------------------
// mwt_pkg
// Types and constants of the memory watchpoint table.
// ----------------------------------------------------------------------------
`default_nettype none

package mwt_pkg;

  localparam int ENTRIES     = 16;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CHECK  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] low_address;
    logic [ADDR_W-1:0] high_address;
    logic [DATA_W-1:0] match_value;
    logic              value_enable;
    logic              on_read;
    logic              on_write;
  } entry_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   access_address;
    logic [DATA_W-1:0]   access_data;
    logic                access_is_write;
    entry_t              bp;
  } req_t;

  typedef struct packed {
    logic    hit;
    status_t status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mwt_table.sv =====
// ----------------------------------------------------------------------------
// mwt_table
// Watchpoint storage with parallel comparators and insert/erase update.
// ----------------------------------------------------------------------------
`default_nettype none

module mwt_table (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          apply,
  input  mwt_pkg::req_t                req,
  output mwt_pkg::rsp_t                rsp,
  output logic [mwt_pkg::ENTRIES-1:0]  valid_o
);
  import mwt_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  entry_t             ent_r [ENTRIES];

  entry_t             bp_norm;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] same_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] slot_oh;
  logic [ENTRIES-1:0] wr_vec;

  always_comb begin
    bp_norm = req.bp;
    if (!req.bp.value_enable) begin
      bp_norm.match_value = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      hit_vec[k] = valid_r[k]
                 && (req.access_address >= ent_r[k].low_address)
                 && (req.access_address <= ent_r[k].high_address)
                 && (!ent_r[k].value_enable || ent_r[k].match_value == req.access_data)
                 && (req.access_is_write ? ent_r[k].on_write : ent_r[k].on_read);
      same_vec[k] = valid_r[k]
                  && (ent_r[k].low_address == bp_norm.low_address)
                  && (ent_r[k].high_address == bp_norm.high_address)
                  && (ent_r[k].value_enable == bp_norm.value_enable)
                  && (ent_r[k].on_read == bp_norm.on_read)
                  && (ent_r[k].on_write == bp_norm.on_write)
                  && (!bp_norm.value_enable || ent_r[k].match_value == bp_norm.match_value);
    end
  end

  assign free_vec = ~valid_r;
  assign slot_oh  = free_vec & (~free_vec + ENTRIES'(1));

  always_comb begin
    valid_nxt  = valid_r;
    wr_vec     = '0;
    rsp.hit    = 1'b0;
    rsp.status = ST_OK;
    unique case (req.action)
      ACT_CHECK: begin
        rsp.hit = |hit_vec;
      end
      ACT_INSERT: begin
        if (|same_vec) begin
          rsp.status = ST_DUP;
        end else if (~|free_vec) begin
          rsp.status = ST_FULL;
        end else begin
          valid_nxt = valid_r | slot_oh;
          wr_vec    = slot_oh;
        end
      end
      ACT_ERASE: begin
        if (|same_vec) begin
          valid_nxt = valid_r & ~same_vec;
        end else begin
          rsp.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (apply) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (apply && wr_vec[k]) begin
        ent_r[k] <= bp_norm;
      end
    end
  end

  assign valid_o = valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/memory_watchpoint_table_core.sv =====
// ----------------------------------------------------------------------------
// memory_watchpoint_table_core
// Bank of address/data watchpoints checked against one bus access per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Input transactions arrive on in_tvalid/in_tready: in_tuser carries the
// action (check, insert, erase) and in_tdata the access and watchpoint fields.
// Every input transaction yields exactly one result transaction on
// out_tvalid/out_tready, in order: the hit flag and a status code.
// A transaction is registered on acceptance, compared against all entries from
// the input register and its result registered in the output register, which
// drives out_tvalid. With the output free one transaction is taken every
// cycle; insert and erase update the table in the same cycle as their
// compare, so the next transaction already sees the change.
// When the receiver stalls, the result holds in the output register and
// one more transaction may wait in the input register; in_tready then drops.
// Reset empties the table (all entries invalid) and clears both registers;
// no clearing pass is needed, the block accepts transactions right after.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module memory_watchpoint_table_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [15:0] access_address, [23:16] access_data, [24] access_is_write,
  // [40:25] bp_low_address, [56:41] bp_high_address, [64:57] bp_match_value,
  // [65] bp_value_enable, [66] bp_on_read, [67] bp_on_write, [71:68] zero
  input  wire [mwt_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] action
  input  wire [mwt_pkg::ACTION_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [0] hit, [2:1] status, [7:3] zero
  output logic [mwt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import mwt_pkg::*;

  logic   s1_valid_r, s1_valid_nxt;
  req_t   s1_r, s1_nxt;
  logic   out_valid_r, out_valid_nxt;
  rsp_t   out_r;
  rsp_t   rsp;
  logic   adv;
  logic   in_fire;
  logic [ENTRIES-1:0] valid_vec;
  logic   stall_both;
  logic   check_adv;
  logic   insert_ok;
  int     valid_cnt;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_nxt.action                = in_tuser;
    s1_nxt.access_address        = in_tdata[15:0];
    s1_nxt.access_data           = in_tdata[23:16];
    s1_nxt.access_is_write       = in_tdata[24];
    s1_nxt.bp.low_address        = in_tdata[40:25];
    s1_nxt.bp.high_address       = in_tdata[56:41];
    s1_nxt.bp.match_value        = in_tdata[64:57];
    s1_nxt.bp.value_enable       = in_tdata[65];
    s1_nxt.bp.on_read            = in_tdata[66];
    s1_nxt.bp.on_write           = in_tdata[67];
  end

  always_comb begin
    priority if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    priority if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  mwt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .apply   (adv),
    .req     (s1_r),
    .rsp     (rsp),
    .valid_o (valid_vec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (adv) begin
      out_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_r.status, out_r.hit};

  assign stall_both = s1_valid_r && out_valid_r && !out_tready;
  assign check_adv  = adv && (s1_r.action == ACT_CHECK);
  assign insert_ok  = adv && (s1_r.action == ACT_INSERT) && (rsp.status == ST_OK);
  assign valid_cnt  = $countones(valid_vec);

  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!s1_valid_r && !out_valid_r), "valid after reset")
  `ASSERT_CLK(a_stall_blocks, stall_both |-> !in_tready, "input taken while stalled")
  `ASSERT_CLK(a_check_status, check_adv |=> (out_r.status == ST_OK), "check status not ok")
  `ASSERT_CLK(a_insert_count, insert_ok |=> (valid_cnt == $past(valid_cnt) + 1), "insert count wrong")

endmodule

`default_nettype wire
